@@ hdl/pulse_width_frame_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pulse width frame receiver checker
// Each macro expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_FRAME_RECEIVER_ASSERT_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define PWFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pwfr assertion failed");

// next-cycle implication
`define PWFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pwfr assertion failed");

`endif

@@ hdl/pwfr_pkg.sv @@
// ----------------------------------------------------------------------------
// pwfr_pkg
// Shared types and constants of the pulse width frame receiver.
// ----------------------------------------------------------------------------
package pwfr_pkg;

    // widths of the fixed fields
    localparam int WIDTH_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int BITCNT_W  = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 2'd3;

    // configuration reset values
    localparam logic [WIDTH_W-1:0] RST_ONE_MIN  = 16'd1000;
    localparam logic [WIDTH_W-1:0] RST_ONE_MAX  = 16'd1600;
    localparam logic [WIDTH_W-1:0] RST_ZERO_MIN = 16'd400;
    localparam logic [WIDTH_W-1:0] RST_ZERO_MAX = 16'd800;

    // bit entered at the top of the shift byte for a one
    localparam logic [BYTE_W-1:0] ONE_BIT_MASK = 8'd128;
    localparam logic [BITCNT_W-1:0] LAST_BIT   = 3'd7;

    // class of one pulse
    typedef enum logic [1:0] {
        PC_NOISE,
        PC_ZERO,
        PC_ONE
    } t_pulse_class;

    // one result item
    typedef struct packed {
        logic              is_length;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] data_index;
        logic              frame_end;
    } t_result;

endpackage

@@ hdl/pwfr_front.sv @@
// ----------------------------------------------------------------------------
// pwfr_front
// Holds the width ranges and classifies each transferred pulse width.
// ----------------------------------------------------------------------------
module pwfr_front
    import pwfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_data,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    output t_pulse_class         o_class
);

    logic [WIDTH_W-1:0] r_one_min;
    logic [WIDTH_W-1:0] r_one_max;
    logic [WIDTH_W-1:0] r_zero_min;
    logic [WIDTH_W-1:0] r_zero_max;
    logic               is_one;
    logic               is_zero;

    // range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_min  <= RST_ONE_MIN;
            r_one_max  <= RST_ONE_MAX;
            r_zero_min <= RST_ZERO_MIN;
            r_zero_max <= RST_ZERO_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ONE_MIN:  r_one_min  <= i_cfg_data;
                CFG_ONE_MAX:  r_one_max  <= i_cfg_data;
                CFG_ZERO_MIN: r_zero_min <= i_cfg_data;
                CFG_ZERO_MAX: r_zero_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // inclusive range checks, one-range wins
    assign is_one  = (i_pulse_width >= r_one_min) && (i_pulse_width <= r_one_max);
    assign is_zero = (i_pulse_width >= r_zero_min) && (i_pulse_width <= r_zero_max);

    always_comb begin
        if (is_one) begin
            o_class = PC_ONE;
        end else if (is_zero) begin
            o_class = PC_ZERO;
        end else begin
            o_class = PC_NOISE;
        end
    end

endmodule

@@ hdl/pwfr_queue.sv @@
// ----------------------------------------------------------------------------
// pwfr_queue
// Short queue of pulse classes between the classifier and the decoder.
// ----------------------------------------------------------------------------
module pwfr_queue
    import pwfr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_pulse_class i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output t_pulse_class o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pulse_class     r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointer wrap
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hdl/pwfr_back.sv @@
// ----------------------------------------------------------------------------
// pwfr_back
// Bit assembly, frame tracking and the output register.
// ----------------------------------------------------------------------------
module pwfr_back
    import pwfr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_pulse_class i_class,
    output logic         o_pop,
    input  logic         i_out_stall,
    output logic         o_out_valid,
    output t_result      o_out
);

    logic                r_awaiting_start;
    logic [BYTE_W-1:0]   r_shift_byte;
    logic [BITCNT_W-1:0] r_bit_count;
    logic [BYTE_W-1:0]   r_byte_position;
    logic [BYTE_W-1:0]   r_declared_length;
    logic                r_out_valid;
    t_result             r_out;

    logic                n_awaiting_start;
    logic [BYTE_W-1:0]   n_shift_byte;
    logic [BITCNT_W-1:0] n_bit_count;
    logic [BYTE_W-1:0]   n_byte_position;
    logic [BYTE_W-1:0]   n_declared_length;
    logic                emit;
    t_result             result;
    logic [BYTE_W-1:0]   shifted;
    logic                done;

    // take a class when the output register can hold a result
    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    // decode step
    always_comb begin
        n_awaiting_start  = r_awaiting_start;
        n_shift_byte      = r_shift_byte;
        n_bit_count       = r_bit_count;
        n_byte_position   = r_byte_position;
        n_declared_length = r_declared_length;
        emit              = 1'b0;
        result            = '0;
        done              = 1'b0;
        shifted           = (r_shift_byte >> 1) | ((i_class == PC_ONE) ? ONE_BIT_MASK : '0);
        if (r_awaiting_start) begin
            if (i_class == PC_ONE) begin
                n_awaiting_start = 1'b0;
            end
        end else if (i_class == PC_NOISE) begin
            // noise drops the partial byte count, keeps frame position
            n_awaiting_start = 1'b1;
            n_bit_count      = '0;
        end else begin
            n_shift_byte = shifted;
            if (r_bit_count != LAST_BIT) begin
                n_bit_count = r_bit_count + 1'b1;
            end else begin
                n_bit_count       = '0;
                emit              = 1'b1;
                result.byte_value = shifted;
                if (r_byte_position == '0) begin
                    // header byte carries the length
                    n_declared_length = shifted;
                    done              = (shifted == '0);
                    result.is_length  = 1'b1;
                    result.data_index = '0;
                end else begin
                    done              = (r_byte_position == r_declared_length);
                    result.is_length  = 1'b0;
                    result.data_index = r_byte_position - 1'b1;
                end
                result.frame_end = done;
                if (done) begin
                    n_awaiting_start = 1'b1;
                    n_byte_position  = '0;
                    n_shift_byte     = '0;
                end else begin
                    n_byte_position = r_byte_position + 1'b1;
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_start  <= 1'b1;
            r_shift_byte      <= '0;
            r_bit_count       <= '0;
            r_byte_position   <= '0;
            r_declared_length <= '0;
        end else if (o_pop) begin
            r_awaiting_start  <= n_awaiting_start;
            r_shift_byte      <= n_shift_byte;
            r_bit_count       <= n_bit_count;
            r_byte_position   <= n_byte_position;
            r_declared_length <= n_declared_length;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/pulse_width_frame_receiver.sv @@
// A result is registered: the pulse that completes its byte passes the class queue, then the output register.
// Throughput: one pulse per cycle while the output is not stalled, limited by the single decode step in the back end.
// The input stalls only while the class queue is full (output held by a stalled receiver).
// Reset: synchronous, active low; clears queue, decoder and output valid and restores
// the default width ranges.
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver
// Classifies pulse widths, assembles LSB-first bytes and frames them by a
// leading length byte.
// ----------------------------------------------------------------------------
module pulse_width_frame_receiver
    import pwfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_length,
    output logic [BYTE_W-1:0]    o_byte_value,
    output logic [BYTE_W-1:0]    o_data_index,
    output logic                 o_frame_end
);

    t_pulse_class front_class;
    t_pulse_class queue_class;
    logic         queue_full;
    logic         queue_empty;
    logic         queue_pop;
    logic         push;
    t_result      out_item;

    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    pwfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pulse_width (i_pulse_width),
        .o_class       (front_class)
    );

    pwfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_class),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_data  (queue_class)
    );

    pwfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_class     (queue_class),
        .o_pop       (queue_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (out_item)
    );

    assign o_is_length  = out_item.is_length;
    assign o_byte_value = out_item.byte_value;
    assign o_data_index = out_item.data_index;
    assign o_frame_end  = out_item.frame_end;

endmodule

@@ hdl/pwfr_checker.sv @@
// ----------------------------------------------------------------------------
// pwfr_checker
// Port-level checks of the pulse width frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "pulse_width_frame_receiver_assert.svh"

module pwfr_checker
    import pwfr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_is_length,
    input logic [BYTE_W-1:0] o_byte_value,
    input logic [BYTE_W-1:0] o_data_index,
    input logic              o_frame_end
);

    // all result fields as one word
    t_result out_word;

    assign out_word = {o_is_length, o_byte_value, o_data_index, o_frame_end};

    // a stalled result holds
    `PWFR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

    // header bytes always sit at index zero
    `PWFR_ASSERT_NOW(a_header_index, o_out_valid && o_is_length, o_data_index == '0)

    // a header that ends the frame declares an empty frame
    `PWFR_ASSERT_NOW(a_empty_frame, o_out_valid && o_is_length && o_frame_end, o_byte_value == '0)

    // payload index never reaches the top code
    `PWFR_ASSERT_NOW(a_payload_index, o_out_valid && !o_is_length, o_data_index != '1)

endmodule

bind pulse_width_frame_receiver pwfr_checker u_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse width frame receiver. Pulse widths are
// sent over the valid/stall input channel. A behavioral decoder classifies
// each accepted pulse, assembles bytes and tracks the frame position, and
// queues the byte records it expects. Every output transfer is checked
// against the oldest queued record. Directed frames, range settings and
// random framed traffic with noise run, mostly with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
    import pwfr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WIDTH_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [WIDTH_W-1:0]   i_pulse_width;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_is_length;
    logic [BYTE_W-1:0]    o_byte_value;
    logic [BYTE_W-1:0]    o_data_index;
    logic                 o_frame_end;

    pulse_width_frame_receiver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pulse_width (i_pulse_width),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_length   (o_is_length),
        .o_byte_value  (o_byte_value),
        .o_data_index  (o_data_index),
        .o_frame_end   (o_frame_end)
    );

    // width ranges as currently programmed
    logic [WIDTH_W-1:0] one_lo  = RST_ONE_MIN;
    logic [WIDTH_W-1:0] one_hi  = RST_ONE_MAX;
    logic [WIDTH_W-1:0] zero_lo = RST_ZERO_MIN;
    logic [WIDTH_W-1:0] zero_hi = RST_ZERO_MAX;

    // decoder state
    logic                rx_waiting = 1'b1;
    logic [BYTE_W-1:0]   rx_shift   = '0;
    logic [BITCNT_W-1:0] rx_bits    = '0;
    logic [BYTE_W-1:0]   rx_pos     = '0;
    logic [BYTE_W-1:0]   rx_len     = '0;

    t_result pending_bytes[$];
    int      mismatches  = 0;
    int      pulses_sent = 0;
    int      cycle_count = 0;
    bit      idle_en     = 1'b1;

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one is checked before zero, so overlapping widths are ones
    function automatic t_pulse_class classify(input logic [WIDTH_W-1:0] w);
        if (w >= one_lo && w <= one_hi)
            return PC_ONE;
        if (w >= zero_lo && w <= zero_hi)
            return PC_ZERO;
        return PC_NOISE;
    endfunction

    // advance the decoder by one accepted pulse, queue any finished byte
    function automatic void decode_pulse(input logic [WIDTH_W-1:0] w);
        t_pulse_class cls;
        t_result      rec;
        cls = classify(w);
        if (rx_waiting) begin
            if (cls == PC_ONE)
                rx_waiting = 1'b0;
            return;
        end
        // noise drops the partial byte count but keeps the frame position
        if (cls == PC_NOISE) begin
            rx_waiting = 1'b1;
            rx_bits    = '0;
            return;
        end
        rx_shift = rx_shift >> 1;
        if (cls == PC_ONE)
            rx_shift = rx_shift | ONE_BIT_MASK;
        if (rx_bits != LAST_BIT) begin
            rx_bits = rx_bits + 1'b1;
            return;
        end
        rx_bits        = '0;
        rec.byte_value = rx_shift;
        if (rx_pos == '0) begin
            rx_len         = rx_shift;
            rec.is_length  = 1'b1;
            rec.data_index = '0;
            rec.frame_end  = (rx_shift == '0);
        end else begin
            rec.is_length  = 1'b0;
            rec.data_index = rx_pos - 1'b1;
            rec.frame_end  = (rx_pos == rx_len);
        end
        pending_bytes.push_back(rec);
        if (rec.frame_end) begin
            rx_waiting = 1'b1;
            rx_pos     = '0;
            rx_shift   = '0;
        end else begin
            rx_pos = rx_pos + 1'b1;
        end
    endfunction

    // random width of the requested class under the current ranges
    function automatic bit pick_width(input t_pulse_class cls,
                                      output logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] cand;
        for (int t = 0; t < 64; t++) begin
            case (cls)
                PC_ONE: begin
                    case ($urandom_range(0, 2))
                        0:       cand = one_lo;
                        1:       cand = one_hi;
                        default: cand = WIDTH_W'($urandom_range(one_lo, one_hi));
                    endcase
                end
                PC_ZERO: begin
                    case ($urandom_range(0, 2))
                        0:       cand = zero_lo;
                        1:       cand = zero_hi;
                        default: cand = WIDTH_W'($urandom_range(zero_lo, zero_hi));
                    endcase
                end
                default: begin
                    // just outside each bound, or anywhere
                    case ($urandom_range(0, 7))
                        0:       cand = one_lo - 16'd1;
                        1:       cand = one_hi + 16'd1;
                        2:       cand = zero_lo - 16'd1;
                        3:       cand = zero_hi + 16'd1;
                        default: cand = WIDTH_W'($urandom_range(0, 16'hFFFF));
                    endcase
                end
            endcase
            if (classify(cand) == cls) begin
                w = cand;
                return 1'b1;
            end
        end
        w = '0;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch, %s: expected len=%0b byte=%02h idx=%0d end=%0b",
                     $realtime, what, want.is_length, want.byte_value,
                     want.data_index, want.frame_end,
                     "; actual len=%0b byte=%02h idx=%0d end=%0b",
                     got.is_length, got.byte_value, got.data_index, got.frame_end);
    endtask

    // check every output transfer against the oldest expected byte
    always @(posedge i_clk) begin : check_bytes
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = {o_is_length, o_byte_value, o_data_index, o_frame_end};
            if (pending_bytes.size() == 0) begin
                report_mismatch("no byte expected", '0, got);
            end else begin
                want = pending_bytes.pop_front();
                if (got.is_length !== want.is_length || got.byte_value !== want.byte_value
                    || got.data_index !== want.data_index
                    || got.frame_end !== want.frame_end)
                    report_mismatch("wrong byte", want, got);
            end
        end
    end

    // receiver side: random stall before each output transfer
    initial begin : out_side
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = idle_en ? $urandom_range(0, 4) : 0;
            if (hold != 0) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk);
            while (!(i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    // send one pulse; entered and left just after a falling edge
    task automatic send_pulse(input logic [WIDTH_W-1:0] w);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_pulse_width = w;
        do @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        decode_pulse(w);
        pulses_sent++;
        @(negedge i_clk);
    endtask

    // start pulse if needed, then eight bits LSB first; noise may cut it short
    task automatic send_byte(input logic [BYTE_W-1:0] value, input int noise_pct,
                             output bit ok);
        logic [WIDTH_W-1:0] w;
        ok = 1'b0;
        if (rx_waiting) begin
            if (!pick_width(PC_ONE, w))
                return;
            send_pulse(w);
        end
        for (int i = 0; i < BYTE_W; i++) begin
            if ($urandom_range(0, 99) < noise_pct && pick_width(PC_NOISE, w)) begin
                send_pulse(w);
                return;
            end
            if (!pick_width(value[i] ? PC_ONE : PC_ZERO, w))
                return;
            send_pulse(w);
        end
        ok = 1'b1;
    endtask

    // close any open frame, then send a length byte and its payload
    task automatic send_frame(input logic [BYTE_W-1:0] len, input int noise_pct);
        logic [BYTE_W-1:0] value;
        bit                ok;
        for (int g = 0; g < 300 && rx_pos != '0; g++)
            send_byte(BYTE_W'($urandom), 0, ok);
        for (int k = 0; k <= len; k++) begin
            value = (k == 0) ? len : BYTE_W'($urandom);
            ok    = 1'b0;
            for (int tries = 0; tries < 50 && !ok; tries++)
                send_byte(value, noise_pct, ok);
        end
    endtask

    // wait until every expected byte is out, plus the pipeline tail
    task automatic wait_until_idle();
        i_in_valid = 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        case (idx)
            CFG_ONE_MIN:  one_lo  = val;
            CFG_ONE_MAX:  one_hi  = val;
            CFG_ZERO_MIN: zero_lo = val;
            CFG_ZERO_MAX: zero_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_ranges(input logic [WIDTH_W-1:0] o_lo, input logic [WIDTH_W-1:0] o_hi,
                              input logic [WIDTH_W-1:0] z_lo, input logic [WIDTH_W-1:0] z_hi);
        wait_until_idle();
        write_reg(CFG_ONE_MIN, o_lo);
        write_reg(CFG_ONE_MAX, o_hi);
        write_reg(CFG_ZERO_MIN, z_lo);
        write_reg(CFG_ZERO_MAX, z_hi);
        i_cfg_we = 1'b0;
    endtask

    // noise, zero-range and out-of-range widths before any start are ignored
    task automatic test_idle_pulses();
        send_pulse(16'd0);
        send_pulse(16'hFFFF);
        send_pulse(16'd600);
        send_pulse(16'd900);
        send_pulse(16'd1601);
        send_pulse(16'd999);
    endtask

    // length byte of zero closes the frame right away
    task automatic test_empty_frame();
        bit ok;
        send_byte(8'h00, 0, ok);
    endtask

    // length one, payload broken by noise and then sent again
    task automatic test_broken_frame();
        bit ok;
        send_pulse(RST_ONE_MIN);
        send_pulse(RST_ONE_MAX);
        send_pulse(RST_ZERO_MIN);
        send_pulse(RST_ZERO_MAX);
        send_pulse(16'd401);
        send_pulse(16'd799);
        send_pulse(16'd600);
        send_pulse(16'd500);
        send_pulse(16'd700);
        send_pulse(RST_ONE_MAX);
        send_pulse(RST_ZERO_MIN);
        send_pulse(16'd1234);
        send_pulse(16'hFFFF);
        send_byte(8'hA5, 0, ok);
    endtask

    // widths in both ranges count as ones
    task automatic test_overlapping_ranges();
        set_ranges(16'd500, 16'd900, 16'd400, 16'd800);
        send_pulse(16'd700);
        send_frame(8'd2, 10);
        send_frame(8'd1, 0);
    endtask

    // single-width ranges and ranges at the ends of the width scale
    task automatic test_narrow_ranges();
        set_ranges(16'd1200, 16'd1200, 16'd700, 16'd700);
        send_frame(8'd1, 10);
        set_ranges(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_frame(8'd2, 10);
        // every width is a bit here, so no noise
        set_ranges(16'd0, 16'd0, 16'd1, 16'hFFFF);
        send_frame(8'd2, 0);
    endtask

    // min above max: that range matches nothing
    task automatic test_empty_ranges();
        set_ranges(16'd2000, 16'd1000, RST_ZERO_MIN, RST_ZERO_MAX);
        send_pulse(16'd1500);
        send_pulse(16'd600);
        send_pulse(16'd0);
        send_pulse(16'hFFFF);
        set_ranges(RST_ONE_MIN, RST_ONE_MAX, 16'd800, 16'd400);
        send_pulse(16'd1300);
        send_pulse(RST_ONE_MIN);
        send_pulse(RST_ONE_MAX);
        send_pulse(16'd600);
    endtask

    // random frames with noise, plus stray pulses between frames
    task automatic run_traffic(input int target);
        int                 stop_at;
        int                 m;
        int                 pick;
        logic [BYTE_W-1:0]  len;
        logic [WIDTH_W-1:0] w;
        stop_at = pulses_sent + target;
        while (pulses_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                // ignored while waiting, so they do not count
                m = pulses_sent;
                repeat ($urandom_range(1, 3))
                    if (pick_width($urandom_range(0, 1) ? PC_NOISE : PC_ZERO, w))
                        send_pulse(w);
                stop_at += pulses_sent - m;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = BYTE_W'($urandom_range(0, 4));
                else if (pick < 95)
                    len = BYTE_W'($urandom_range(5, 12));
                else
                    len = BYTE_W'($urandom_range(13, 40));
                send_frame(len, $urandom_range(0, 1) ? 0 : $urandom_range(3, 15));
            end
        end
    endtask

    task automatic test_default_traffic();
        set_ranges(RST_ONE_MIN, RST_ONE_MAX, RST_ZERO_MIN, RST_ZERO_MAX);
        idle_en = 1'b1;
        run_traffic(150);
        // back-to-back stretch
        idle_en = 1'b0;
        run_traffic(40);
        idle_en = 1'b1;
    endtask

    // adjoining ranges with noise only at the far ends
    task automatic test_adjacent_ranges();
        set_ranges(16'd3000, 16'd3100, 16'd10, 16'd2999);
        run_traffic(40);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ONE_MIN;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pulse_width = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_pulses();
        test_empty_frame();
        test_broken_frame();
        test_overlapping_ranges();
        test_narrow_ranges();
        test_empty_ranges();
        test_default_traffic();
        test_adjacent_ranges();

        wait_until_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
